// ----- rtl/flha_pkg.sv -----
// flha_pkg: shared types, constants and codes of the free list heap allocator
// no dependencies
package flha_pkg;

  localparam int ARENA_BYTES  = 65536;
  localparam int ALIGN_BYTES  = 4;
  localparam int HEADER_BYTES = 8;
  localparam int LINK_BYTES   = 8;
  localparam int SPLIT_BYTES  = HEADER_BYTES + LINK_BYTES;
  localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
  localparam int SLOTS        = ARENA_BYTES / ALIGN_BYTES;
  localparam int SLOT_BITS    = $clog2(SLOTS);
  localparam int HDR_SLOTS    = HEADER_BYTES / ALIGN_BYTES;

  // slot index and a nullable pointer whose top bit marks null
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [SLOT_BITS:0]   ptr_t;

  localparam int   NIL_BIT  = SLOT_BITS;
  localparam ptr_t PTR_NIL  = ptr_t'(1) << SLOT_BITS;
  localparam logic [15:0] INIT_SIZE = 16'(ARENA_BYTES - HEADER_BYTES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NONE  = 2'd3;

  localparam logic REG_FIT_MODE = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [15:0] request_bytes;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_offset;
    logic [15:0] granted_bytes;
  } rsp_t;

  typedef struct packed {
    logic  valid;
    rsp_t  data;
  } res_t;

  // write ports of the two stores
  typedef struct packed {
    logic        size_we;
    slot_t       size_addr;
    logic [15:0] size_data;
    logic        link_we;
    slot_t       link_addr;
    ptr_t        link_data;
  } wr_t;

endpackage

// ----- rtl/flha_mem.sv -----
// flha_mem: block size store and free link store, one read address, one write each
// depends on flha_pkg
module flha_mem (
  input  logic               clk,
  input  logic               rst,
  input  flha_pkg::slot_t    rd_addr,
  output logic [15:0]        rd_size,
  output flha_pkg::ptr_t     rd_link,
  input  flha_pkg::wr_t      wr
);

  logic [15:0]    size_mem [flha_pkg::SLOTS];
  flha_pkg::ptr_t link_mem [flha_pkg::SLOTS];

  // reset rewrites the header of the single arena-wide block
  always_ff @(posedge clk) begin
    if (rst) begin
      size_mem[0] <= flha_pkg::INIT_SIZE;
    end else if (wr.size_we) begin
      size_mem[wr.size_addr] <= wr.size_data;
    end
    rd_size <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mem[0] <= flha_pkg::PTR_NIL;
    end else if (wr.link_we) begin
      link_mem[wr.link_addr] <= wr.link_data;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule

// ----- rtl/flha_ctrl.sv -----
// flha_ctrl: sequencer that walks the free list and block chain and rewrites headers
// depends on flha_pkg
module flha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         fit,
  input  flha_pkg::req_t     req,
  input  logic               req_fire,
  output logic               idle,
  output flha_pkg::res_t     res,
  input  logic               res_take,
  output flha_pkg::slot_t    rd_addr,
  input  logic [15:0]        rd_size,
  input  flha_pkg::ptr_t     rd_link,
  output flha_pkg::wr_t      wr
);

  typedef enum logic [13:0] {
    IDLE    = 14'b00000000000001,
    A_WALK  = 14'b00000000000010,
    A_EVAL  = 14'b00000000000100,
    A_LINK  = 14'b00000000001000,
    F_CHAIN = 14'b00000000010000,
    F_CHECK = 14'b00000000100000,
    F_SCAN  = 14'b00000001000000,
    F_RDI   = 14'b00000010000000,
    F_RDN   = 14'b00000100000000,
    F_RDP   = 14'b00001000000000,
    F_MRG   = 14'b00010000000000,
    F_LNK   = 14'b00100000000000,
    F_PST   = 14'b01000000000000,
    DONE    = 14'b10000000000000
  } state_t;

  localparam int SB = flha_pkg::SLOT_BITS;
  localparam int NB = flha_pkg::NIL_BIT;

  state_t          state;
  flha_pkg::ptr_t  head;
  flha_pkg::ptr_t  cur;
  flha_pkg::ptr_t  prev;
  flha_pkg::ptr_t  pick;
  flha_pkg::ptr_t  pick_prev;
  flha_pkg::ptr_t  pick_link;
  flha_pkg::ptr_t  repl;
  flha_pkg::ptr_t  fp;
  flha_pkg::ptr_t  past;
  flha_pkg::ptr_t  next;
  flha_pkg::ptr_t  link_next;
  flha_pkg::ptr_t  info_link_new;
  flha_pkg::slot_t info;
  logic [16:0]     want;
  logic [15:0]     pick_size;
  logic [15:0]     grant;
  logic [15:0]     size_info;
  logic [15:0]     size_next;
  logic [15:0]     size_past;
  logic [15:0]     info_size_new;
  flha_pkg::rsp_t  res_data;

  logic [16:0]     want_first;
  logic [16:0]     want_in;
  logic [16:0]     size_wide;
  logic            walk_take;
  logic            walk_hit;
  logic            walk_stop;
  logic [16:0]     diff;
  logic            split;
  flha_pkg::slot_t repl_idx;
  logic [15:0]     rem_size;
  logic [SB:0]     chain_step;
  logic            chain_more;
  logic            fp_hit;
  logic            merge_next;
  logic            merge_past;
  logic            free_bad;
  flha_pkg::slot_t info_in;

  // request rounding: at least a link, then aligned
  assign want_first = (req.request_bytes < 16'(flha_pkg::LINK_BYTES)) ?
                      17'(flha_pkg::LINK_BYTES) : {1'b0, req.request_bytes};
  assign want_in    = (want_first + 17'(flha_pkg::ALIGN_BYTES - 1)) &
                      ~17'(flha_pkg::ALIGN_BYTES - 1);

  assign free_bad = (req.block_offset < 16'(flha_pkg::HEADER_BYTES)) ||
                    (req.block_offset[flha_pkg::ALIGN_SHIFT-1:0] != '0);
  assign info_in  = SB'(req.block_offset >> flha_pkg::ALIGN_SHIFT) -
                    SB'(flha_pkg::HDR_SLOTS);

  // fit decision on the node just read
  always_comb begin
    size_wide = {1'b0, rd_size};
    walk_take = 1'b0;
    walk_hit  = 1'b0;
    unique case (fit)
      flha_pkg::FIT_FIRST: begin
        if (size_wide >= want) begin
          walk_take = 1'b1;
          walk_hit  = 1'b1;
        end
      end
      flha_pkg::FIT_BEST: begin
        if (size_wide == want) begin
          walk_take = 1'b1;
          walk_hit  = 1'b1;
        end else if (size_wide > want && (pick[NB] || rd_size < pick_size)) begin
          walk_take = 1'b1;
        end
      end
      flha_pkg::FIT_WORST: begin
        if (size_wide > want && (pick[NB] || rd_size > pick_size)) begin
          walk_take = 1'b1;
        end
      end
      default: begin
        walk_take = 1'b0;
      end
    endcase
    walk_stop = walk_hit || rd_link[NB];
  end

  assign diff     = {1'b0, pick_size} - want;
  assign split    = diff >= 17'(flha_pkg::SPLIT_BYTES);
  assign repl_idx = pick[SB-1:0] + SB'(flha_pkg::HDR_SLOTS) +
                    SB'(want >> flha_pkg::ALIGN_SHIFT);
  assign rem_size = pick_size - want[15:0] - 16'(flha_pkg::HEADER_BYTES);

  assign chain_step = cur + (SB+1)'(flha_pkg::HDR_SLOTS) +
                      (SB+1)'(rd_size >> flha_pkg::ALIGN_SHIFT);
  assign chain_more = chain_step < {1'b0, info};
  assign fp_hit     = !fp[NB] && (fp[SB-1:0] == cur[SB-1:0]);

  assign merge_next = !next[NB] &&
                      (({1'b0, info} + (SB+1)'(flha_pkg::HDR_SLOTS) +
                        (SB+1)'(size_info >> flha_pkg::ALIGN_SHIFT)) == next);
  assign merge_past = ({1'b0, past[SB-1:0]} + (SB+1)'(flha_pkg::HDR_SLOTS) +
                       (SB+1)'(size_past >> flha_pkg::ALIGN_SHIFT)) == {1'b0, info};

  // read address for the next cycle
  always_comb begin
    unique case (state)
      IDLE:    rd_addr = (req.cmd == flha_pkg::CMD_FREE) ? '0 : head[SB-1:0];
      A_WALK:  rd_addr = rd_link[SB-1:0];
      F_CHAIN: rd_addr = chain_step[SB-1:0];
      F_CHECK: rd_addr = head[SB-1:0];
      F_SCAN:  rd_addr = rd_link[SB-1:0];
      F_RDI:   rd_addr = info;
      F_RDN:   rd_addr = next[SB-1:0];
      F_RDP:   rd_addr = past[SB-1:0];
      default: rd_addr = '0;
    endcase
  end

  // header rewrites
  always_comb begin
    wr = '0;
    unique case (state)
      A_EVAL: begin
        if (!pick[NB] && split) begin
          wr.size_we   = 1'b1;
          wr.size_addr = repl_idx;
          wr.size_data = rem_size;
          wr.link_we   = 1'b1;
          wr.link_addr = repl_idx;
          wr.link_data = pick_link;
        end
      end
      A_LINK: begin
        wr.size_we   = 1'b1;
        wr.size_addr = pick[SB-1:0];
        wr.size_data = grant;
        wr.link_we   = !pick_prev[NB];
        wr.link_addr = pick_prev[SB-1:0];
        wr.link_data = repl;
      end
      F_CHECK: begin
        wr.link_we   = (cur == {1'b0, info}) && !(!fp[NB] && fp[SB-1:0] == info) &&
                       head[NB];
        wr.link_addr = info;
        wr.link_data = flha_pkg::PTR_NIL;
      end
      F_MRG: begin
        wr.size_we   = 1'b1;
        wr.size_addr = info;
        wr.size_data = merge_next ?
                       size_info + size_next + 16'(flha_pkg::HEADER_BYTES) : size_info;
        wr.link_we   = 1'b1;
        wr.link_addr = info;
        wr.link_data = merge_next ? link_next : next;
      end
      F_LNK: begin
        wr.link_we   = next != past;
        wr.link_addr = past[SB-1:0];
        wr.link_data = {1'b0, info};
      end
      F_PST: begin
        wr.size_we   = merge_past;
        wr.size_addr = past[SB-1:0];
        wr.size_data = size_past + info_size_new + 16'(flha_pkg::HEADER_BYTES);
        wr.link_we   = merge_past;
        wr.link_addr = past[SB-1:0];
        wr.link_data = info_link_new;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      head  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_fire) begin
            // status is set by every path before the done state
            res_data.payload_offset <= '0;
            res_data.granted_bytes  <= '0;
            if (req.cmd == flha_pkg::CMD_ALLOC) begin
              want      <= want_in;
              pick      <= flha_pkg::PTR_NIL;
              prev      <= flha_pkg::PTR_NIL;
              cur       <= {1'b0, head[SB-1:0]};
              if (fit == flha_pkg::FIT_NONE || head[NB]) begin
                res_data.status <= flha_pkg::ST_NOFIT;
                state           <= DONE;
              end else begin
                state <= A_WALK;
              end
            end else begin
              info <= info_in;
              cur  <= '0;
              fp   <= head;
              if (free_bad) begin
                res_data.status <= flha_pkg::ST_BADFREE;
                state           <= DONE;
              end else if (info_in == '0) begin
                state <= F_CHECK;
              end else begin
                state <= F_CHAIN;
              end
            end
          end
        end
        A_WALK: begin
          if (walk_take) begin
            pick      <= {1'b0, cur[SB-1:0]};
            pick_prev <= prev;
            pick_size <= rd_size;
            pick_link <= rd_link;
          end
          prev <= {1'b0, cur[SB-1:0]};
          cur  <= {1'b0, rd_link[SB-1:0]};
          if (walk_stop) begin
            state <= A_EVAL;
          end
        end
        A_EVAL: begin
          if (pick[NB]) begin
            res_data.status <= flha_pkg::ST_NOFIT;
            state           <= DONE;
          end else begin
            repl  <= split ? {1'b0, repl_idx} : pick_link;
            grant <= split ? want[15:0] : pick_size;
            state <= A_LINK;
          end
        end
        A_LINK: begin
          if (pick_prev[NB]) begin
            head <= repl;
          end
          res_data.status         <= flha_pkg::ST_OK;
          res_data.payload_offset <= (16'(pick[SB-1:0]) << flha_pkg::ALIGN_SHIFT) +
                                     16'(flha_pkg::HEADER_BYTES);
          res_data.granted_bytes  <= grant;
          state                   <= DONE;
        end
        F_CHAIN: begin
          if (fp_hit) begin
            fp <= rd_link;
          end
          cur <= chain_step;
          if (!chain_more) begin
            state <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (cur != {1'b0, info} || (!fp[NB] && fp[SB-1:0] == info)) begin
            res_data.status <= flha_pkg::ST_BADFREE;
            state           <= DONE;
          end else if (head[NB]) begin
            head            <= {1'b0, info};
            res_data.status <= flha_pkg::ST_OK;
            state           <= DONE;
          end else begin
            past  <= head;
            next  <= head;
            state <= (head[SB-1:0] < info) ? F_SCAN : F_RDI;
          end
        end
        F_SCAN: begin
          past <= next;
          next <= rd_link;
          if (rd_link[NB] || rd_link[SB-1:0] >= info) begin
            state <= F_RDI;
          end
        end
        F_RDI: begin
          if (past[SB-1:0] == info || (!next[NB] && next[SB-1:0] == info)) begin
            res_data.status <= flha_pkg::ST_BADFREE;
            state           <= DONE;
          end else begin
            state <= F_RDN;
          end
        end
        F_RDN: begin
          size_info <= rd_size;
          state     <= F_RDP;
        end
        F_RDP: begin
          size_next <= rd_size;
          link_next <= rd_link;
          state     <= F_MRG;
        end
        F_MRG: begin
          size_past     <= rd_size;
          info_size_new <= merge_next ?
                           size_info + size_next + 16'(flha_pkg::HEADER_BYTES) : size_info;
          info_link_new <= merge_next ? link_next : next;
          state         <= F_LNK;
        end
        F_LNK: begin
          if (next == past) begin
            head <= {1'b0, info};
          end
          state <= F_PST;
        end
        F_PST: begin
          res_data.status <= flha_pkg::ST_OK;
          state           <= DONE;
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign idle       = state == IDLE;
  assign res.valid  = state == DONE;
  assign res.data   = res_data;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state != IDLE)
    else $error("accepted beat did not start a sequence");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && !res_take) |=> (state == DONE && $stable(res_data)))
    else $error("pending result changed before it was taken");

  a_chain_in_arena: assert property (@(posedge clk) disable iff (rst)
    state == F_CHAIN |-> cur < (SB+1)'(flha_pkg::SLOTS))
    else $error("chain walk left the arena");

  a_grant_covers: assert property (@(posedge clk) disable iff (rst)
    state == A_LINK |-> (!want[16] && grant >= want[15:0]))
    else $error("grant smaller than rounded request");

endmodule

// ----- rtl/free_list_heap_allocator_unit.sv -----
// free_list_heap_allocator_unit: top level, config register, result register
// depends on flha_pkg, flha_mem, flha_ctrl
//
//  channel   dir   handshake                      payload
//  req       in    req_valid / req_ready          flha_pkg::req_t (cmd, bytes, offset)
//  rsp       out   rsp_valid / rsp_ready          flha_pkg::rsp_t (status, offset, bytes)
//  apb       in    psel, penable, pwrite, pready  paddr, pwdata, prdata (fit_mode)
//
// one beat in flight at a time; memory reads are registered, one node per cycle
// alloc walks the free list nodes, then evaluates the pick and relinks; free walks
//   the block chain before the target, then the free list nodes below it, then merges
// reset is synchronous; it rewrites the entry zero headers, no clearing pass
// a stalled rsp holds in the output register; the core then waits in its
// done state and req_ready stays low until it hands the beat over
module free_list_heap_allocator_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  flha_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output flha_pkg::rsp_t  rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [1:0]      fit_mode;
  logic            idle;
  logic            req_fire;
  logic            res_take;
  flha_pkg::res_t  res;
  flha_pkg::slot_t rd_addr;
  logic [15:0]     rd_size;
  flha_pkg::ptr_t  rd_link;
  flha_pkg::wr_t   wr;

  // apb register file: only fit_mode, selected when paddr[2] is zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == flha_pkg::REG_FIT_MODE) ? {30'd0, fit_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= flha_pkg::FIT_FIRST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == flha_pkg::REG_FIT_MODE) begin
      fit_mode <= pwdata[1:0];
    end
  end

  // input side: the sequencer takes a beat only when it sits idle
  assign req_ready = idle;
  assign req_fire  = req_valid && req_ready;

  // output register decouples the sequencer from the consumer
  assign res_take = res.valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res.data;
    end
  end

  flha_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_size (rd_size),
    .rd_link (rd_link),
    .wr      (wr)
  );

  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fit      (fit_mode),
    .req      (req),
    .req_fire (req_fire),
    .idle     (idle),
    .res      (res),
    .res_take (res_take),
    .rd_addr  (rd_addr),
    .rd_size  (rd_size),
    .rd_link  (rd_link),
    .wr       (wr)
  );

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for free_list_heap_allocator_unit
// depends on flha_pkg and the allocator rtl; predicts each result from its own heap model
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = flha_pkg::ARENA_BYTES / flha_pkg::ALIGN_BYTES + 1;
  localparam int HOLD_LIMIT = 400000;
  localparam logic [31:0] NIL_OFF = 32'hFFFF_FFFF;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  flha_pkg::req_t  req = '0;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  flha_pkg::rsp_t  rsp;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  free_list_heap_allocator_unit uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // heap model: payload size and free link per header slot
  logic [15:0] size_of [NSLOT];
  logic [31:0] link_of [NSLOT];
  logic [31:0] head_off;
  logic [1:0]  fit_sel;

  flha_pkg::req_t pending_beats[$];
  flha_pkg::rsp_t awaited_rsps[$];
  int   live_offsets[$];   // payload offsets the bench believes are allocated
  int   errors = 0;
  int   idle_cycles = 0;
  int   req_gap = 0;
  int   rsp_gap = 0;

  function automatic logic [31:0] sz(logic [31:0] off);
    int i;
    i = off / flha_pkg::ALIGN_BYTES;
    return (i < NSLOT) ? {16'h0, size_of[i]} : 32'h0;
  endfunction

  function automatic void put_sz(logic [31:0] off, logic [31:0] v);
    int i;
    i = off / flha_pkg::ALIGN_BYTES;
    if (i < NSLOT) size_of[i] = v[15:0];
  endfunction

  function automatic logic [31:0] lnk(logic [31:0] off);
    int i;
    i = off / flha_pkg::ALIGN_BYTES;
    return (i < NSLOT) ? link_of[i] : NIL_OFF;
  endfunction

  function automatic void put_lnk(logic [31:0] off, logic [31:0] v);
    int i;
    i = off / flha_pkg::ALIGN_BYTES;
    if (i < NSLOT) link_of[i] = v;
  endfunction

  function automatic void heap_reset();
    foreach (size_of[i]) begin
      size_of[i] = '0;
      link_of[i] = '0;
    end
    size_of[0] = 16'(flha_pkg::ARENA_BYTES - flha_pkg::HEADER_BYTES);
    link_of[0] = NIL_OFF;
    head_off = 0;
    fit_sel = flha_pkg::FIT_FIRST;
  endfunction

  function automatic flha_pkg::rsp_t heap_alloc(logic [15:0] bytes);
    flha_pkg::rsp_t r;
    logic [31:0] want, t, cur, prev, pick, pick_prev, s, repl;
    r = '0;
    want = (bytes < flha_pkg::LINK_BYTES) ? flha_pkg::LINK_BYTES : bytes;
    t = (flha_pkg::HEADER_BYTES + want) % flha_pkg::ALIGN_BYTES;
    if (t != 0) want += flha_pkg::ALIGN_BYTES - t;
    r.status = flha_pkg::ST_NOFIT;
    if (fit_sel == flha_pkg::FIT_NONE) return r;
    cur = head_off; prev = NIL_OFF; pick = NIL_OFF; pick_prev = NIL_OFF;
    for (int n = 0; n < NSLOT && cur != NIL_OFF; n++) begin
      s = sz(cur);
      if (fit_sel == flha_pkg::FIT_FIRST) begin
        if (s >= want) begin
          pick = cur; pick_prev = prev; break;
        end
      end else if (fit_sel == flha_pkg::FIT_BEST) begin
        if (s == want) begin
          pick = cur; pick_prev = prev; break;
        end
        if (s > want && (pick == NIL_OFF || s < sz(pick))) begin
          pick = cur; pick_prev = prev;
        end
      end else begin
        if (s > want && (pick == NIL_OFF || s > sz(pick))) begin
          pick = cur; pick_prev = prev;
        end
      end
      prev = cur;
      cur = lnk(cur);
    end
    if (pick == NIL_OFF) return r;
    s = sz(pick);
    if (s - want < flha_pkg::SPLIT_BYTES) want = s;
    if (want != s) begin
      repl = pick + flha_pkg::HEADER_BYTES + want;
      put_sz(repl, s - want - flha_pkg::HEADER_BYTES);
      put_lnk(repl, lnk(pick));
    end else begin
      repl = lnk(pick);
    end
    put_sz(pick, want);
    if (pick_prev == NIL_OFF) head_off = repl;
    else put_lnk(pick_prev, repl);
    r.status = flha_pkg::ST_OK;
    r.payload_offset = 16'(pick + flha_pkg::HEADER_BYTES);
    r.granted_bytes = want[15:0];
    return r;
  endfunction

  function automatic flha_pkg::rsp_t heap_free(logic [15:0] off);
    flha_pkg::rsp_t r;
    logic [31:0] info, cur, fp, past, nxt;
    r = '0;
    r.status = flha_pkg::ST_BADFREE;
    if (off < flha_pkg::HEADER_BYTES) return r;
    info = off - flha_pkg::HEADER_BYTES;
    cur = 0;
    fp = head_off;
    while (cur < info && cur < flha_pkg::ARENA_BYTES) begin
      if (fp == cur) fp = lnk(fp);
      cur += flha_pkg::HEADER_BYTES + sz(cur);
    end
    if (cur != info || cur == fp) return r;
    r.status = flha_pkg::ST_OK;
    if (head_off == NIL_OFF) begin
      head_off = info;
      put_lnk(info, NIL_OFF);
      return r;
    end
    past = head_off;
    nxt = head_off;
    for (int n = 0; n < NSLOT && nxt != NIL_OFF && nxt < info; n++) begin
      past = nxt;
      nxt = lnk(nxt);
    end
    if (info == past || info == nxt) begin
      r.status = flha_pkg::ST_BADFREE;
      return r;
    end
    if (nxt != NIL_OFF && info + flha_pkg::HEADER_BYTES + sz(info) == nxt) begin
      put_sz(info, sz(info) + sz(nxt) + flha_pkg::HEADER_BYTES);
      put_lnk(info, lnk(nxt));
    end else begin
      put_lnk(info, nxt);
    end
    if (nxt != past) put_lnk(past, info);
    else head_off = info;
    if (past + flha_pkg::HEADER_BYTES + sz(past) == info) begin
      put_sz(past, sz(past) + sz(info) + flha_pkg::HEADER_BYTES);
      put_lnk(past, lnk(info));
    end
    return r;
  endfunction

  // driver: one beat at a time from the pending queue, random gap before most, some back to back
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        if (req.cmd == flha_pkg::CMD_ALLOC)
          awaited_rsps.push_back(heap_alloc(req.request_bytes));
        else awaited_rsps.push_back(heap_free(req.block_offset));
        void'(pending_beats.pop_front());
        if (pending_beats.size() != 0 && $urandom_range(0, 7) == 0) begin
          // back to back: keep valid high with the next payload
          req <= pending_beats[0];
          req_gap <= 0;
        end else begin
          req_valid <= 1'b0;
          req_gap <= $urandom_range(0, 7);
        end
      end else if (!req_valid && pending_beats.size() != 0) begin
        if (req_gap > 0) req_gap <= req_gap - 1;
        else begin
          req_valid <= 1'b1;
          req <= pending_beats[0];
        end
      end
    end
  end

  // monitor: random ready stalls, compare against oldest expected result
  always @(posedge clk) begin
    flha_pkg::rsp_t exp_r;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t unexpected rsp beat: actual %h", $time, rsp);
          errors++;
        end else begin
          exp_r = awaited_rsps.pop_front();
          if (rsp.status !== exp_r.status)
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, rsp.status);
          if (rsp.payload_offset !== exp_r.payload_offset)
            $display("%0t payload_offset mismatch: expected %0d actual %0d",
                     $time, exp_r.payload_offset, rsp.payload_offset);
          if (rsp.granted_bytes !== exp_r.granted_bytes)
            $display("%0t granted_bytes mismatch: expected %0d actual %0d",
                     $time, exp_r.granted_bytes, rsp.granted_bytes);
          if (rsp !== exp_r) errors++;
          else if (exp_r.status == flha_pkg::ST_OK && exp_r.granted_bytes != 0)
            live_offsets.push_back(exp_r.payload_offset);
        end
        rsp_gap <= $urandom_range(0, 7);
        rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HOLD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_beat(logic c, logic [15:0] b, logic [15:0] o);
    flha_pkg::req_t r;
    r.cmd = c;
    r.request_bytes = b;
    r.block_offset = o;
    pending_beats.push_back(r);
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || awaited_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // apb write, only while the block is idle
  task automatic set_fit(logic [1:0] m);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(flha_pkg::REG_FIT_MODE) << 2;
    pwdata <= 32'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    fit_sel = m;
  endtask

  // free a remembered block, or a wrong offset now and then
  task automatic queue_free_pick();
    int k;
    if (live_offsets.size() != 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      queue_beat(flha_pkg::CMD_FREE, 16'($urandom), 16'(live_offsets[k]));
      // a repeat of a freed offset makes a double free later
      if ($urandom_range(0, 5) != 0) live_offsets.delete(k);
    end else begin
      queue_beat(flha_pkg::CMD_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0 || live_offsets.size() == 0) begin
        case ($urandom_range(0, 5))
          0: queue_beat(flha_pkg::CMD_ALLOC, 16'($urandom), 16'($urandom));
          1: queue_beat(flha_pkg::CMD_ALLOC, 16'($urandom_range(0, 16)), 16'($urandom));
          default: queue_beat(flha_pkg::CMD_ALLOC, 16'($urandom_range(0, 600)),
                              16'($urandom));
        endcase
      end else begin
        queue_free_pick();
      end
      // let results come back so live offsets stay current
      if (pending_beats.size() > 4) while (pending_beats.size() > 1) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    heap_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, bad frees, double free, coalescing, empty free list
    queue_beat(flha_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
    queue_beat(flha_pkg::CMD_ALLOC, 16'd5, 16'd0);
    queue_beat(flha_pkg::CMD_ALLOC, 16'd13, 16'd0);
    queue_beat(flha_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
    queue_beat(flha_pkg::CMD_FREE, 16'hFFFF, 16'd0);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd7);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'hFFFF);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd12);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd24);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd24);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd8);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd40);
    queue_beat(flha_pkg::CMD_ALLOC, 16'd65520, 16'd0);
    queue_beat(flha_pkg::CMD_ALLOC, 16'd20, 16'd0);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd8);
    queue_beat(flha_pkg::CMD_ALLOC, 16'd65528, 16'd0);
    queue_beat(flha_pkg::CMD_FREE, 16'd0, 16'd8);
    drain();
    // sender holds off here until every result is back
    set_fit(flha_pkg::FIT_BEST);
    random_phase(200);
    set_fit(flha_pkg::FIT_WORST);
    random_phase(200);
    set_fit(flha_pkg::FIT_NONE);
    random_phase(40);
    set_fit(flha_pkg::FIT_FIRST);
    random_phase(200);
    set_fit(flha_pkg::FIT_BEST);
    random_phase(190);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
